// ===== hw/rtl/fea_pkg.sv =====
// Package with the item types and status codes of the free extent allocator.
package fea_pkg;

    // Width of addresses and lengths held in the extent table.
    localparam int ADDR_BITS = 16;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_LIST  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOFIT   = 3'd1,
        ST_FULL    = 3'd2,
        ST_OVERLAP = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] range_start;
        logic [15:0] range_length;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] extent_start;
        logic [15:0] extent_length;
        logic        last;
    } t_rsp;

    // Write request from the sequencer to the extent table.
    typedef struct packed {
        logic        we;
        logic [31:0] data;
    } t_tbl_wr;

endpackage

// ===== hw/rtl/fea_table.sv =====
// Extent table memory: one packed start/length word per entry, registered read.
module fea_table #(
    parameter int IDX_BITS = 4,
    parameter int AW       = 16
) (
    input  logic                i_clk,
    input  logic [IDX_BITS-1:0] i_raddr,
    input  logic [IDX_BITS-1:0] i_waddr,
    input  fea_pkg::t_tbl_wr    i_wr,
    output logic [2*AW-1:0]     o_rdata
);
    localparam int DEPTH = 1 << IDX_BITS;

    logic [2*AW-1:0] r_mem [DEPTH];

    // Synchronous write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_waddr] <= i_wr.data[2*AW-1:0];
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/free_extent_allocator.sv =====
// Top level of the free extent allocator: request sequencer around the extent table.
//
//  Channel | Signals                          | Direction
//  --------+----------------------------------+----------
//  request | i_req_valid o_req_ready i_req    | in
//  result  | o_rsp_valid i_rsp_ready o_rsp    | out
//  config  | i_cfg_we i_cfg_wdata             | in
//
// One request at a time. A request scans the table through the single read port,
// one entry a cycle, then decides, moves entries (read, then write) for an insert,
// split or removal, and writes back. A list request emits one item per entry, each
// waiting for i_rsp_ready. Reset and a pool_length write rewrite entry 0 and the
// count; the result register holds its item while the consumer stalls.
module free_extent_allocator #(
    parameter int MAX_EXTENTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  fea_pkg::t_req       i_req,
    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    output fea_pkg::t_rsp       o_rsp,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata
);
    localparam int IB = (MAX_EXTENTS > 2) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CB = $clog2(MAX_EXTENTS + 1);
    localparam int AW = fea_pkg::ADDR_BITS;
    localparam logic [CB-1:0] MAXC = CB'(MAX_EXTENTS);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCAN  = 9'b000000010,
        S_DEC   = 9'b000000100,
        S_SHUP  = 9'b000001000,
        S_SHDN  = 9'b000010000,
        S_FIN   = 9'b000100000,
        S_LIST  = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_INIT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [CB-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_pool, n_pool;
    logic [1:0] r_op, n_op;
    logic [AW:0] r_s, n_s, r_e, n_e;
    // Scan bookkeeping: issue index, compare index, pipeline valid.
    logic [CB-1:0] r_ri, n_ri, r_ci, n_ci;
    logic r_pv, n_pv;
    // Findings of the scan.
    logic r_found, n_found, r_ovl, n_ovl;
    logic [CB-1:0] r_hit, n_hit, r_pos, n_pos;
    logic r_posset, n_posset;
    logic [AW:0] r_ha, n_ha, r_hb, n_hb;   // containing extent start/end
    logic [AW:0] r_pa, n_pa, r_pe, n_pe;   // prev start/end for free
    logic [AW:0] r_na, n_na, r_nb, n_nb;   // next start/end for free
    // Final write and shift control.
    logic [CB-1:0] r_k, n_k, r_stop, n_stop;
    logic [CB-1:0] r_fidx, n_fidx;
    logic [2*AW-1:0] r_fdat, n_fdat;
    logic r_fwe, n_fwe;
    logic [CB-1:0] r_x, n_x;
    logic [2*AW-1:0] r_xdat, n_xdat;
    logic r_xwe, n_xwe;
    logic [CB-1:0] r_dcnt, n_dcnt;
    logic [2:0] r_st, n_st;
    logic r_ov, n_ov;
    fea_pkg::t_rsp r_rsp, n_rsp;

    logic [IB-1:0] raddr, waddr;
    fea_pkg::t_tbl_wr wr;
    logic [2*AW-1:0] rdata;
    logic [AW:0] ra, rb;

    fea_table #(.IDX_BITS(IB), .AW(AW)) u_table (
        .i_clk  (i_clk),
        .i_raddr(raddr),
        .i_waddr(waddr),
        .i_wr   (wr),
        .o_rdata(rdata)
    );

    assign ra = {1'b0, rdata[2*AW-1:AW]};
    assign rb = ra + {1'b0, rdata[AW-1:0]};
    assign o_req_ready = (r_state == S_IDLE) && !r_ov;
    assign o_rsp_valid = r_ov;
    assign o_rsp = r_rsp;

    // Sequencer: scan, decide, shift, write back, answer; also list and table init.
    always_comb begin
        logic [AW-1:0] ms, ml;
        logic [AW:0] e;
        n_state = r_state; n_cnt = r_cnt; n_pool = r_pool; n_op = r_op;
        n_s = r_s; n_e = r_e; n_ri = r_ri; n_ci = r_ci; n_pv = 1'b0;
        n_found = r_found; n_ovl = r_ovl; n_hit = r_hit; n_pos = r_pos;
        n_posset = r_posset; n_ha = r_ha; n_hb = r_hb; n_pa = r_pa; n_pe = r_pe;
        n_na = r_na; n_nb = r_nb; n_k = r_k; n_stop = r_stop; n_fidx = r_fidx;
        n_fdat = r_fdat; n_fwe = r_fwe; n_x = r_x; n_xdat = r_xdat; n_xwe = r_xwe;
        n_dcnt = r_dcnt; n_st = r_st; n_ov = r_ov; n_rsp = r_rsp;
        raddr = r_ri[IB-1:0];
        waddr = r_x[IB-1:0];
        wr.we = 1'b0;
        wr.data = 32'(r_xdat);
        ms = i_req.range_start[AW-1:0];
        ml = i_req.range_length[AW-1:0];
        e = {1'b0, ms} + {1'b0, ml};

        if (r_ov && i_rsp_ready) n_ov = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid && !r_ov) begin
                    n_op = i_req.op; n_s = {1'b0, ms}; n_e = e;
                    n_ri = '0; n_ci = '0; n_found = 1'b0; n_ovl = 1'b0;
                    n_posset = 1'b0; n_pos = r_cnt; n_hit = '0;
                    n_pa = '0; n_pe = '0; n_na = '0; n_nb = '0;
                    n_ha = '0; n_hb = '0;
                    if (i_req.op == fea_pkg::OP_LIST) begin
                        if (r_cnt == '0) begin
                            n_rsp = '{status: fea_pkg::ST_EMPTY, extent_start: '0,
                                      extent_length: '0, last: 1'b1};
                            n_ov = 1'b1;
                        end else begin
                            n_state = S_LIST;
                        end
                    end else if ((i_req.op == fea_pkg::OP_ALLOC ||
                                  i_req.op == fea_pkg::OP_FREE) && ml != '0) begin
                        n_state = S_SCAN;
                    end else begin
                        n_rsp = '{status: fea_pkg::ST_OK, extent_start: '0,
                                  extent_length: '0, last: 1'b1};
                        n_ov = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                // Issue one read a cycle; evaluate the entry that returns.
                if (r_ri < r_cnt) begin
                    n_ri = r_ri + 1'b1;
                    n_pv = 1'b1;
                end
                if (r_pv) begin
                    n_ci = r_ci + 1'b1;
                    if (r_op == fea_pkg::OP_ALLOC) begin
                        if (!r_found && r_s >= ra && r_e <= rb) begin
                            n_found = 1'b1; n_hit = r_ci; n_ha = ra; n_hb = rb;
                        end
                    end else begin
                        if (r_s < rb && ra < r_e) n_ovl = 1'b1;
                        if (!r_posset) begin
                            if (ra < r_s) begin
                                n_pa = ra; n_pe = rb;
                            end else begin
                                n_posset = 1'b1; n_pos = r_ci; n_na = ra; n_nb = rb;
                            end
                        end
                    end
                end
                if (!r_pv && r_ri >= r_cnt) n_state = S_DEC;
            end
            S_DEC: begin
                n_st = fea_pkg::ST_OK; n_fwe = 1'b0; n_xwe = 1'b0;
                n_state = S_FIN; n_dcnt = r_cnt;
                if (r_op == fea_pkg::OP_ALLOC) begin
                    if (!r_found) n_st = fea_pkg::ST_NOFIT;
                    else if (r_s == r_ha && r_e == r_hb) begin
                        // Remove entry: shift following entries down.
                        n_dcnt = r_cnt - 1'b1; n_k = r_hit; n_state = S_SHDN;
                    end else if (r_s == r_ha) begin
                        n_fwe = 1'b1; n_fidx = r_hit;
                        n_fdat = {r_e[AW-1:0], AW'(r_hb - r_e)};
                    end else if (r_e == r_hb) begin
                        n_fwe = 1'b1; n_fidx = r_hit;
                        n_fdat = {r_ha[AW-1:0], AW'(r_s - r_ha)};
                    end else if (r_cnt >= MAXC) begin
                        n_st = fea_pkg::ST_FULL;
                    end else begin
                        // Split: trim head first, tail goes into an opened slot.
                        n_xwe = 1'b1; n_x = r_hit;
                        n_xdat = {r_ha[AW-1:0], AW'(r_s - r_ha)};
                        n_fwe = 1'b1; n_fidx = r_hit + 1'b1;
                        n_fdat = {r_e[AW-1:0], AW'(r_hb - r_e)};
                        n_dcnt = r_cnt + 1'b1; n_k = r_cnt;
                        n_stop = r_hit + 1'b1; n_state = S_SHUP;
                    end
                end else begin
                    logic jp, jn;
                    jp = (r_pos != '0) && (r_pe == r_s);
                    jn = (r_pos < r_cnt) && (r_na == r_e);
                    if (r_e > {1'b0, r_pool} || r_ovl) n_st = fea_pkg::ST_OVERLAP;
                    else if (jp && jn) begin
                        n_xwe = 1'b1; n_x = r_pos - 1'b1;
                        n_xdat = {r_pa[AW-1:0], AW'(r_nb - r_pa)};
                        n_dcnt = r_cnt - 1'b1; n_k = r_pos; n_state = S_SHDN;
                    end else if (jp) begin
                        n_fwe = 1'b1; n_fidx = r_pos - 1'b1;
                        n_fdat = {r_pa[AW-1:0], AW'(r_e - r_pa)};
                    end else if (jn) begin
                        n_fwe = 1'b1; n_fidx = r_pos;
                        n_fdat = {r_s[AW-1:0], AW'(r_nb - r_s)};
                    end else if (r_cnt >= MAXC) begin
                        n_st = fea_pkg::ST_FULL;
                    end else begin
                        n_fwe = 1'b1; n_fidx = r_pos;
                        n_fdat = {r_s[AW-1:0], AW'(r_e - r_s)};
                        n_dcnt = r_cnt + 1'b1; n_k = r_cnt;
                        n_stop = r_pos; n_state = S_SHUP;
                    end
                end
            end
            S_SHUP: begin
                // Write the pending entry, then read entry k-1 for k.
                if (r_xwe) begin
                    wr.we = 1'b1; n_xwe = 1'b0;
                end else if (r_pv) begin
                    wr.we = 1'b1; waddr = r_k[IB-1:0]; wr.data = 32'(rdata);
                    n_k = r_k - 1'b1;
                end
                if (!r_pv && !r_xwe || r_pv) begin
                    if (n_k > r_stop && !r_pv) begin
                        raddr = IB'(n_k - 1'b1); n_pv = 1'b1;
                    end else if (n_k <= r_stop) begin
                        n_state = S_FIN;
                    end
                end
                if (r_xwe) begin
                    n_pv = 1'b0;
                end
            end
            S_SHDN: begin
                // Copy entry k+1 into k until the old end.
                if (r_xwe) begin
                    wr.we = 1'b1; n_xwe = 1'b0;
                end else if (r_pv) begin
                    wr.we = 1'b1; waddr = r_k[IB-1:0]; wr.data = 32'(rdata);
                    n_k = r_k + 1'b1;
                end
                if (!r_xwe) begin
                    if (!r_pv && (r_k + 1'b1) < r_cnt) begin
                        raddr = IB'(r_k + 1'b1); n_pv = 1'b1;
                    end else if (!r_pv) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (r_fwe) begin
                    wr.we = 1'b1; waddr = r_fidx[IB-1:0]; wr.data = 32'(r_fdat);
                    n_fwe = 1'b0;
                end
                if (!r_ov) begin
                    n_cnt = (r_st == fea_pkg::ST_OK) ? r_dcnt : r_cnt;
                    n_rsp = '{status: r_st, extent_start: '0,
                              extent_length: '0, last: 1'b1};
                    n_ov = 1'b1; n_state = S_IDLE;
                end
            end
            S_LIST: begin
                // Read entry ri; it appears on the next cycle.
                if (!r_ov || i_rsp_ready) begin
                    raddr = r_ri[IB-1:0]; n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_rsp.status = fea_pkg::ST_OK;
                n_rsp.extent_start = 16'(rdata[2*AW-1:AW]);
                n_rsp.extent_length = 16'(rdata[AW-1:0]);
                n_rsp.last = (r_ri + 1'b1 == r_cnt);
                n_ov = 1'b1;
                n_ri = r_ri + 1'b1;
                n_state = (r_ri + 1'b1 == r_cnt) ? S_IDLE : S_LIST;
            end
            S_INIT: begin
                wr.we = 1'b1; waddr = '0;
                wr.data = 32'({{AW{1'b0}}, r_pool});
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // A pool write rebuilds the table as one extent, or as an empty table for a zero pool.
        if (i_cfg_we) begin
            n_pool = i_cfg_wdata[AW-1:0];
            n_cnt = (i_cfg_wdata[AW-1:0] != '0) ? CB'(1) : '0;
            n_state = S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt <= CB'(1);
            r_pool <= AW'(16'hFFFF);
            r_ov <= 1'b0;
            r_pv <= 1'b0;
            r_fwe <= 1'b0;
            r_xwe <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_pool <= n_pool;
            r_ov <= n_ov;
            r_pv <= n_pv;
            r_fwe <= n_fwe;
            r_xwe <= n_xwe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_s <= n_s; r_e <= n_e; r_ri <= n_ri; r_ci <= n_ci;
        r_found <= n_found; r_ovl <= n_ovl; r_hit <= n_hit; r_pos <= n_pos;
        r_posset <= n_posset; r_ha <= n_ha; r_hb <= n_hb; r_pa <= n_pa;
        r_pe <= n_pe; r_na <= n_na; r_nb <= n_nb; r_k <= n_k; r_stop <= n_stop;
        r_fidx <= n_fidx; r_fdat <= n_fdat; r_x <= n_x; r_xdat <= n_xdat;
        r_dcnt <= n_dcnt; r_st <= n_st; r_rsp <= n_rsp;
    end
endmodule

// ===== dv/extent_checker.sv =====
// Checker that predicts and compares the results of the free extent allocator.
`timescale 1ns / 1ps

module extent_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_ready,
    input  fea_pkg::t_req i_req,
    input  logic          i_rsp_valid,
    input  logic          i_rsp_ready,
    input  fea_pkg::t_rsp i_rsp,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata,
    output int            o_errors,
    output int            o_pending
);

    localparam int MAX_EXT = 16;

    logic [15:0]   ext_start [MAX_EXT];
    logic [15:0]   ext_len   [MAX_EXT];
    int            ext_count;
    logic [15:0]   pool_len;
    fea_pkg::t_rsp expected_q [$];
    int            err_count = 0;

    assign o_errors  = err_count;
    assign o_pending = expected_q.size();

    // Rebuild the table as one extent covering the whole pool, or empty for a zero pool.
    function automatic void init_table(input logic [15:0] plen);
        pool_len = plen;
        for (int k = 0; k < MAX_EXT; k++) begin
            ext_start[k] = '0;
            ext_len[k] = '0;
        end
        ext_len[0] = plen;
        ext_count = (plen != 0) ? 1 : 0;
    endfunction

    function automatic void open_slot(input int pos);
        for (int k = ext_count; k > pos; k--) begin
            ext_start[k] = ext_start[k - 1];
            ext_len[k] = ext_len[k - 1];
        end
        ext_count++;
    endfunction

    function automatic void close_slot(input int pos);
        for (int k = pos; k + 1 < ext_count; k++) begin
            ext_start[k] = ext_start[k + 1];
            ext_len[k] = ext_len[k + 1];
        end
        ext_count--;
    endfunction

    // Carve [s, e) out of the extent that holds it.
    function automatic fea_pkg::t_status allocate_range(input logic [16:0] s,
                                                        input logic [16:0] e);
        logic [16:0] a;
        logic [16:0] b;
        for (int i = 0; i < ext_count; i++) begin
            a = {1'b0, ext_start[i]};
            b = a + {1'b0, ext_len[i]};
            if (s >= a && e <= b) begin
                if (s == a && e == b) begin
                    close_slot(i);
                end else if (s == a) begin
                    ext_start[i] = e[15:0];
                    ext_len[i] = 16'(b - e);
                end else if (e == b) begin
                    ext_len[i] = 16'(s - a);
                end else begin
                    if (ext_count >= MAX_EXT) return fea_pkg::ST_FULL;
                    open_slot(i + 1);
                    ext_start[i + 1] = e[15:0];
                    ext_len[i + 1] = 16'(b - e);
                    ext_len[i] = 16'(s - a);
                end
                return fea_pkg::ST_OK;
            end
        end
        return fea_pkg::ST_NOFIT;
    endfunction

    // Return [s, e) to the table, merging with its neighbors.
    function automatic fea_pkg::t_status release_range(input logic [16:0] s,
                                                       input logic [16:0] e);
        int pos;
        logic [16:0] a;
        logic [16:0] b;
        bit join_prev;
        bit join_next;
        if (e > {1'b0, pool_len}) return fea_pkg::ST_OVERLAP;
        for (int i = 0; i < ext_count; i++) begin
            a = {1'b0, ext_start[i]};
            b = a + {1'b0, ext_len[i]};
            if (s < b && a < e) return fea_pkg::ST_OVERLAP;
        end
        pos = 0;
        while (pos < ext_count && {1'b0, ext_start[pos]} < s) pos++;
        join_prev = pos > 0 &&
            ({1'b0, ext_start[pos - 1]} + {1'b0, ext_len[pos - 1]} == s);
        join_next = pos < ext_count && ({1'b0, ext_start[pos]} == e);
        if (join_prev && join_next) begin
            ext_len[pos - 1] = 16'({1'b0, ext_start[pos]} + {1'b0, ext_len[pos]} -
                                   {1'b0, ext_start[pos - 1]});
            close_slot(pos);
        end else if (join_prev) begin
            ext_len[pos - 1] = 16'(e - {1'b0, ext_start[pos - 1]});
        end else if (join_next) begin
            ext_len[pos] = 16'({1'b0, ext_start[pos]} + {1'b0, ext_len[pos]} - s);
            ext_start[pos] = s[15:0];
        end else begin
            if (ext_count >= MAX_EXT) return fea_pkg::ST_FULL;
            open_slot(pos);
            ext_start[pos] = s[15:0];
            ext_len[pos] = 16'(e - s);
        end
        return fea_pkg::ST_OK;
    endfunction

    // Queue the results one request causes.
    function automatic void predict_request(input fea_pkg::t_req req);
        fea_pkg::t_rsp r;
        logic [16:0] s;
        logic [16:0] e;
        fea_pkg::t_status st;
        s = {1'b0, req.range_start};
        e = s + {1'b0, req.range_length};
        st = fea_pkg::ST_OK;
        if (req.op == fea_pkg::OP_LIST) begin
            if (ext_count == 0) begin
                r = '{status: fea_pkg::ST_EMPTY, extent_start: '0, extent_length: '0,
                      last: 1'b1};
                expected_q.push_back(r);
            end
            for (int i = 0; i < ext_count; i++) begin
                r = '{status: fea_pkg::ST_OK, extent_start: ext_start[i],
                      extent_length: ext_len[i], last: (i + 1 == ext_count)};
                expected_q.push_back(r);
            end
            return;
        end
        if (req.op == fea_pkg::OP_ALLOC && req.range_length != 0) st = allocate_range(s, e);
        else if (req.op == fea_pkg::OP_FREE && req.range_length != 0)
            st = release_range(s, e);
        r = '{status: st, extent_start: '0, extent_length: '0, last: 1'b1};
        expected_q.push_back(r);
    endfunction

    // Watch the channels at each rising edge.
    always @(posedge i_clk) begin
        fea_pkg::t_rsp want;
        if (!i_rst_n) begin
            init_table(16'hFFFF);
            expected_q.delete();
        end else begin
            if (i_cfg_we) init_table(i_cfg_wdata);
            if (i_req_valid && i_req_ready) predict_request(i_req);
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result item %p", i_rsp);
                    err_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_rsp.status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, i_rsp.status);
                        err_count++;
                    end
                    if (i_rsp.extent_start !== want.extent_start) begin
                        $error("extent_start expected %0d actual %0d",
                               want.extent_start, i_rsp.extent_start);
                        err_count++;
                    end
                    if (i_rsp.extent_length !== want.extent_length) begin
                        $error("extent_length expected %0d actual %0d",
                               want.extent_length, i_rsp.extent_length);
                        err_count++;
                    end
                    if (i_rsp.last !== want.last) begin
                        $error("last expected %0d actual %0d", want.last, i_rsp.last);
                        err_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Stimulus and verdict for the free extent allocator testbench.
`timescale 1ns / 1ps

module testbench;

    localparam int TIMEOUT_CYCLES = 400000;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    fea_pkg::t_req req = '0;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    fea_pkg::t_rsp rsp;
    logic          cfg_we = 1'b0;
    logic [15:0]   cfg_wdata = '0;
    int            errors;
    int            pending;
    int            cycles = 0;
    bit            long_stall = 1'b0;
    logic [15:0]   pool_now = 16'hFFFF;

    always #5 clk = ~clk;

    free_extent_allocator uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_req_valid(req_valid), .o_req_ready(req_ready), .i_req(req),
        .o_rsp_valid(rsp_valid), .i_rsp_ready(rsp_ready), .o_rsp(rsp),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata)
    );

    extent_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_req_valid(req_valid), .i_req_ready(req_ready), .i_req(req),
        .i_rsp_valid(rsp_valid), .i_rsp_ready(rsp_ready), .i_rsp(rsp),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .o_errors(errors), .o_pending(pending)
    );

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > TIMEOUT_CYCLES) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, quiet stretches, and one long hold-off.
    initial begin
        int mode;
        mode = 0;
        forever begin
            @(negedge clk);
            if (long_stall) begin
                rsp_ready <= 1'b0;
                repeat (300) @(negedge clk);
                long_stall = 1'b0;
            end
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
            case (mode)
                0: rsp_ready <= 1'b1;
                1: rsp_ready <= ($urandom_range(0, 3) != 0);
                default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Offer one item and hold it until accepted.
    task automatic send_item(input fea_pkg::t_op op, input logic [15:0] s,
                             input logic [15:0] len);
        req_valid <= 1'b1;
        req <= '{op: op, range_start: s, range_length: len};
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pause_sender();
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
    endtask

    // Wait for every result, then let the block settle before a config write.
    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_pool(input logic [15:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        pool_now = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Well-formed sequences with random content plus noise.
    task automatic random_phase(input int count);
        int kind;
        int burst;
        logic [15:0] s;
        logic [15:0] len;
        logic [16:0] span;
        burst = $urandom_range(1, 12);
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 19);
            span = (pool_now == 0) ? 17'd1 : {1'b0, pool_now};
            s = 16'($urandom_range(0, span - 1));
            len = 16'($urandom_range(1, (span - s > 40) ? 40 : span - s));
            if (kind < 8) begin
                send_item(fea_pkg::OP_ALLOC, s, len);
                if ($urandom_range(0, 1)) send_item(fea_pkg::OP_FREE, s, len);
            end else if (kind < 13) send_item(fea_pkg::OP_FREE, s, len);
            else if (kind < 16) send_item(fea_pkg::OP_LIST, 16'($urandom), 16'($urandom));
            else if (kind < 18) send_item(fea_pkg::t_op'($urandom_range(0, 1)),
                                          16'($urandom), 16'($urandom));
            else if (kind < 19) send_item(fea_pkg::OP_NONE, 16'($urandom), 16'($urandom));
            else send_item(fea_pkg::OP_ALLOC, 16'($urandom_range(0, 255)),
                           16'($urandom_range(0, 2)));
            if (--burst == 0) begin
                pause_sender();
                burst = $urandom_range(1, 12);
            end
        end
    endtask

    initial begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, every op, zero length, misfit, overlap, beyond pool.
        send_item(fea_pkg::OP_LIST, 16'h0, 16'h0);
        send_item(fea_pkg::OP_ALLOC, 16'h0, 16'h0);
        send_item(fea_pkg::OP_FREE, 16'h0, 16'h0);
        send_item(fea_pkg::OP_ALLOC, 16'h0, 16'hFFFF);
        send_item(fea_pkg::OP_LIST, 16'hFFFF, 16'hFFFF);
        send_item(fea_pkg::OP_FREE, 16'h10, 16'h10);
        send_item(fea_pkg::OP_FREE, 16'hFFF0, 16'hFFFF);
        send_item(fea_pkg::OP_ALLOC, 16'h20, 16'h20);
        send_item(fea_pkg::OP_FREE, 16'h0, 16'h30);
        send_item(fea_pkg::OP_FREE, 16'h0, 16'h20);
        send_item(fea_pkg::OP_FREE, 16'h40, 16'hFFBF);
        send_item(fea_pkg::OP_NONE, 16'hFFFF, 16'hFFFF);
        send_item(fea_pkg::OP_ALLOC, 16'hFFFF, 16'h1);

        // Fill the table with splits until it reports full.
        write_pool(16'd64);
        for (int k = 0; k < 17; k++) send_item(fea_pkg::OP_ALLOC, 16'(4 * k + 1), 16'd1);
        send_item(fea_pkg::OP_LIST, 16'h0, 16'h0);
        send_item(fea_pkg::OP_FREE, 16'd1, 16'd1);
        send_item(fea_pkg::OP_ALLOC, 16'd0, 16'd1);
        send_item(fea_pkg::OP_FREE, 16'd1, 16'd1);
        send_item(fea_pkg::OP_ALLOC, 16'd10, 16'd70);

        // Zero pool, then the smallest pool.
        write_pool(16'd0);
        send_item(fea_pkg::OP_LIST, 16'h0, 16'h0);
        send_item(fea_pkg::OP_FREE, 16'h0, 16'h1);
        write_pool(16'd1);
        send_item(fea_pkg::OP_ALLOC, 16'h0, 16'h1);
        send_item(fea_pkg::OP_LIST, 16'h0, 16'h0);
        send_item(fea_pkg::OP_FREE, 16'h0, 16'h1);

        // Long receiver hold-off while items keep coming.
        write_pool(16'd96);
        long_stall = 1'b1;
        random_phase(20);
        drain();

        random_phase(30);
        write_pool(16'd200);
        random_phase(25);
        write_pool(16'hFFFF);
        random_phase(20);
        write_pool(16'd48);
        random_phase(13);
        drain();
        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);

        if (errors == 0) $display("testbench: PASS");
        else $display("testbench: FAIL");
        $finish;
    end

endmodule
